>>> hw/rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Shared widths, command codes, microcode word layout and the control program.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int DEF_COLS = 80;
    localparam int DEF_ROWS = 25;

    localparam int CMD_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int COLOR_W = 8;
    localparam int CELL_W  = 16;

    localparam logic [CMD_W-1:0] CMD_PUT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd4;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT_PRINT,
        ST_NEWLINE,
        ST_ROW_INC,
        ST_CR,
        ST_COPY,
        ST_DRAIN,
        ST_FILL_ROW,
        ST_CLEAR,
        ST_SET,
        ST_READ,
        ST_READ_WAIT,
        ST_WRITE,
        ST_RESULT
    } step_t;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_FILL_ZERO,
        MEM_FILL_BLANK,
        MEM_COPY,
        MEM_PUT,
        MEM_WRITE,
        MEM_READ
    } mem_op_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_COL0,
        CUR_ROW_INC,
        CUR_COL_STEP,
        CUR_HOME,
        CUR_SET
    } cur_op_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_ROW_LAST,
        C_COL_LAST,
        C_COPY_MORE,
        C_CELLS_MORE,
        C_OUT_BUSY,
        C_DISPATCH
    } cond_t;

    typedef struct packed {
        mem_op_t mem;
        cur_op_t cur;
        logic    ptr_inc;
        logic    take;
        logic    out_load;
        logic    val_cap;
        cond_t   cond;
        step_t   jump;
        step_t   next;
    } ucode_t;

    typedef struct packed {
        logic row_last;
        logic col_last;
        logic copy_more;
        logic cells_more;
        logic out_busy;
    } dp_status_t;

    // First step of the program for a newly accepted command.
    function automatic step_t entry_step(input logic [CMD_W-1:0] cmd,
                                         input logic [CHAR_W-1:0] ch);
        step_t s;
        unique case (cmd)
            CMD_PUT: begin
                if (ch == CH_NEWLINE) begin
                    s = ST_NEWLINE;
                end else if (ch == CH_RETURN) begin
                    s = ST_CR;
                end else begin
                    s = ST_PUT_PRINT;
                end
            end
            CMD_CLEAR: s = ST_CLEAR;
            CMD_SET:   s = ST_SET;
            CMD_READ:  s = ST_READ;
            CMD_WRITE: s = ST_WRITE;
            default:   s = ST_RESULT;
        endcase
        return s;
    endfunction

    // Control store: one word per step. A true condition takes jump, else next.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        unique case (step)
            ST_INIT:      w = '{MEM_FILL_ZERO, CUR_HOLD, 1'b1, 1'b0, 1'b0, 1'b0,
                                C_CELLS_MORE, ST_INIT, ST_IDLE};
            ST_IDLE:      w = '{MEM_NONE, CUR_HOLD, 1'b0, 1'b1, 1'b0, 1'b0,
                                C_DISPATCH, ST_IDLE, ST_IDLE};
            ST_PUT_PRINT: w = '{MEM_PUT, CUR_COL_STEP, 1'b0, 1'b0, 1'b0, 1'b0,
                                C_COL_LAST, ST_NEWLINE, ST_RESULT};
            ST_NEWLINE:   w = '{MEM_NONE, CUR_COL0, 1'b0, 1'b0, 1'b0, 1'b0,
                                C_ROW_LAST, ST_COPY, ST_ROW_INC};
            ST_ROW_INC:   w = '{MEM_NONE, CUR_ROW_INC, 1'b0, 1'b0, 1'b0, 1'b0,
                                C_ALWAYS, ST_RESULT, ST_RESULT};
            ST_CR:        w = '{MEM_NONE, CUR_COL0, 1'b0, 1'b0, 1'b0, 1'b0,
                                C_ALWAYS, ST_RESULT, ST_RESULT};
            ST_COPY:      w = '{MEM_COPY, CUR_HOLD, 1'b1, 1'b0, 1'b0, 1'b0,
                                C_COPY_MORE, ST_COPY, ST_DRAIN};
            ST_DRAIN:     w = '{MEM_NONE, CUR_HOLD, 1'b0, 1'b0, 1'b0, 1'b0,
                                C_ALWAYS, ST_FILL_ROW, ST_FILL_ROW};
            ST_FILL_ROW:  w = '{MEM_FILL_BLANK, CUR_HOLD, 1'b1, 1'b0, 1'b0, 1'b0,
                                C_CELLS_MORE, ST_FILL_ROW, ST_RESULT};
            ST_CLEAR:     w = '{MEM_FILL_BLANK, CUR_HOME, 1'b1, 1'b0, 1'b0, 1'b0,
                                C_CELLS_MORE, ST_CLEAR, ST_RESULT};
            ST_SET:       w = '{MEM_NONE, CUR_SET, 1'b0, 1'b0, 1'b0, 1'b0,
                                C_ALWAYS, ST_RESULT, ST_RESULT};
            ST_READ:      w = '{MEM_READ, CUR_HOLD, 1'b0, 1'b0, 1'b0, 1'b0,
                                C_ALWAYS, ST_READ_WAIT, ST_READ_WAIT};
            ST_READ_WAIT: w = '{MEM_NONE, CUR_HOLD, 1'b0, 1'b0, 1'b0, 1'b1,
                                C_ALWAYS, ST_RESULT, ST_RESULT};
            ST_WRITE:     w = '{MEM_WRITE, CUR_HOLD, 1'b0, 1'b0, 1'b0, 1'b0,
                                C_ALWAYS, ST_RESULT, ST_RESULT};
            ST_RESULT:    w = '{MEM_NONE, CUR_HOLD, 1'b0, 1'b0, 1'b1, 1'b0,
                                C_OUT_BUSY, ST_RESULT, ST_IDLE};
            default:      w = '{MEM_NONE, CUR_HOLD, 1'b0, 1'b0, 1'b0, 1'b0,
                                C_ALWAYS, ST_IDLE, ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// Text console cursor engine
// Character screen with cursor, printing, wrap, scroll, clear and cell access.
// ----------------------------------------------------------------------------
// After reset the block clears all ROWS*COLS cells to zero, one cell per
// clock, and takes no command until that pass is done; color writes are
// taken meanwhile. A microcoded sequencer then runs each command as a short
// program over one single-port-read, single-port-write screen memory, so
// that memory sets the timing. A scroll copies rows up one cell per clock
// and then blanks the last row. A finished result sits in an output
// register, so the next command may start while it waits to be transferred.
module text_console_cursor_engine #(
    parameter int COLS = tcce_pkg::DEF_COLS,
    parameter int ROWS = tcce_pkg::DEF_ROWS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tcce_pkg::COLOR_W-1:0]  cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tcce_pkg::CMD_W-1:0]    s_cmd,
    input  logic [tcce_pkg::CHAR_W-1:0]   s_char_code,
    input  logic [tcce_pkg::ROW_W-1:0]    s_row,
    input  logic [tcce_pkg::COL_W-1:0]    s_col,
    input  logic [tcce_pkg::COLOR_W-1:0]  s_cell_color,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tcce_pkg::ROW_W-1:0]    m_pos_row,
    output logic [tcce_pkg::COL_W-1:0]    m_pos_col,
    output logic [tcce_pkg::CELL_W-1:0]   m_cell_value,
    output logic                          m_cell_written
);
    import tcce_pkg::*;

    ucode_t     cw;
    dp_status_t status;
    logic       accept;

    assign accept = s_valid && s_ready;

    tcce_sequencer u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_cmd       (s_cmd),
        .s_char_code (s_char_code),
        .status      (status),
        .cw          (cw),
        .ready       (s_ready)
    );

    tcce_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cw             (cw),
        .accept         (accept),
        .s_char_code    (s_char_code),
        .s_row          (s_row),
        .s_col          (s_col),
        .s_cell_color   (s_cell_color),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .m_ready        (m_ready),
        .status         (status),
        .m_valid        (m_valid),
        .m_pos_row      (m_pos_row),
        .m_pos_col      (m_pos_col),
        .m_cell_value   (m_cell_value),
        .m_cell_written (m_cell_written)
    );

endmodule

>>> hw/rtl/tcce_sequencer.sv
// ----------------------------------------------------------------------------
// Text console microcode sequencer
// Step counter over the control store with conditional jumps and dispatch.
// ----------------------------------------------------------------------------
module tcce_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic [tcce_pkg::CMD_W-1:0]    s_cmd,
    input  logic [tcce_pkg::CHAR_W-1:0]   s_char_code,
    input  tcce_pkg::dp_status_t          status,
    output tcce_pkg::ucode_t              cw,
    output logic                          ready
);
    import tcce_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  taken;

    assign cw    = ucode_rom(step_reg);
    assign ready = cw.take;

    always_comb begin
        unique case (cw.cond)
            C_ALWAYS:     taken = 1'b1;
            C_ROW_LAST:   taken = status.row_last;
            C_COL_LAST:   taken = status.col_last;
            C_COPY_MORE:  taken = status.copy_more;
            C_CELLS_MORE: taken = status.cells_more;
            C_OUT_BUSY:   taken = status.out_busy;
            C_DISPATCH:   taken = 1'b0;
            default:      taken = 1'b0;
        endcase

        if (cw.cond == C_DISPATCH && s_valid) begin
            step_next = entry_step(s_cmd, s_char_code);
        end else if (taken) begin
            step_next = cw.jump;
        end else begin
            step_next = cw.next;
        end
    end

    // Out of reset the program runs the clearing pass before going idle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_INIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

>>> hw/rtl/tcce_datapath.sv
// ----------------------------------------------------------------------------
// Text console datapath
// Screen memory, cursor, sweep pointer, operand latches and result register.
// ----------------------------------------------------------------------------
module tcce_datapath #(
    parameter int COLS = tcce_pkg::DEF_COLS,
    parameter int ROWS = tcce_pkg::DEF_ROWS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tcce_pkg::ucode_t              cw,
    input  logic                          accept,
    input  logic [tcce_pkg::CHAR_W-1:0]   s_char_code,
    input  logic [tcce_pkg::ROW_W-1:0]    s_row,
    input  logic [tcce_pkg::COL_W-1:0]    s_col,
    input  logic [tcce_pkg::COLOR_W-1:0]  s_cell_color,
    input  logic                          cfg_wr_en,
    input  logic [tcce_pkg::COLOR_W-1:0]  cfg_wr_data,
    input  logic                          m_ready,
    output tcce_pkg::dp_status_t          status,
    output logic                          m_valid,
    output logic [tcce_pkg::ROW_W-1:0]    m_pos_row,
    output logic [tcce_pkg::COL_W-1:0]    m_pos_col,
    output logic [tcce_pkg::CELL_W-1:0]   m_cell_value,
    output logic                          m_cell_written
);
    import tcce_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] COLS_A    = AW'(COLS);
    localparam logic [AW-1:0] COPY_LAST = AW'((ROWS - 1) * COLS - 1);
    localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLS - 1);

    logic [CELL_W-1:0]  mem [CELLS];

    logic [COLOR_W-1:0] color_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic [AW-1:0]      ptr_reg;
    logic [AW-1:0]      wptr_reg;
    logic               pend_reg;
    logic [CELL_W-1:0]  rdata_reg;

    logic [CHAR_W-1:0]  ch_reg;
    logic [ROW_W-1:0]   irow_reg;
    logic [COL_W-1:0]   icol_reg;
    logic [COLOR_W-1:0] icolor_reg;
    logic [CELL_W-1:0]  value_reg;
    logic               written_reg;

    logic               m_valid_reg;
    logic [ROW_W-1:0]   m_row_reg;
    logic [COL_W-1:0]   m_col_reg;
    logic [CELL_W-1:0]  m_value_reg;
    logic               m_written_reg;

    logic               in_range;
    logic [AW-1:0]      item_addr;
    logic [AW-1:0]      cur_addr;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic [CELL_W-1:0]  wdata;
    logic               we;
    logic               out_load;
    logic [ROW_W-1:0]   set_row;
    logic [COL_W-1:0]   set_col;

    assign in_range  = (int'(irow_reg) < ROWS) && (int'(icol_reg) < COLS);
    assign item_addr = AW'(AW'(irow_reg) * COLS_A) + AW'(icol_reg);
    assign cur_addr  = AW'(AW'(row_reg) * COLS_A) + AW'(col_reg);
    assign set_row   = (int'(irow_reg) < ROWS) ? irow_reg : ROW_MAX;
    assign set_col   = (int'(icol_reg) < COLS) ? icol_reg : COL_MAX;

    assign status.row_last   = (row_reg == ROW_MAX);
    assign status.col_last   = (col_reg == COL_MAX);
    assign status.copy_more  = (ptr_reg != COPY_LAST);
    assign status.cells_more = (ptr_reg != CELL_LAST);
    assign status.out_busy   = m_valid_reg && !m_ready;

    assign out_load = cw.out_load && !status.out_busy;

    // A scroll copy is pipelined: the cell read in one cycle is written
    // one row up in the next, so the write side trails the read side.
    always_comb begin
        raddr = in_range ? item_addr : '0;
        if (cw.mem == MEM_COPY) begin
            raddr = ptr_reg + COLS_A;
        end

        we    = 1'b0;
        waddr = ptr_reg;
        wdata = '0;
        if (pend_reg) begin
            we    = 1'b1;
            waddr = wptr_reg;
            wdata = rdata_reg;
        end else begin
            case (cw.mem)
                MEM_FILL_ZERO: begin
                    we = 1'b1;
                end
                MEM_FILL_BLANK: begin
                    we    = 1'b1;
                    wdata = {color_reg, CH_SPACE};
                end
                MEM_PUT: begin
                    we    = 1'b1;
                    waddr = cur_addr;
                    wdata = {color_reg, ch_reg};
                end
                MEM_WRITE: begin
                    we    = in_range;
                    waddr = item_addr;
                    wdata = {icolor_reg, ch_reg};
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg   <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                color_reg <= cfg_wr_data;
            end

            pend_reg <= (cw.mem == MEM_COPY);
            wptr_reg <= ptr_reg;

            if (accept) begin
                ptr_reg <= '0;
            end else if (cw.ptr_inc) begin
                ptr_reg <= ptr_reg + AW'(1);
            end

            case (cw.cur)
                CUR_COL0: begin
                    col_reg <= '0;
                end
                CUR_ROW_INC: begin
                    row_reg <= row_reg + ROW_W'(1);
                end
                CUR_COL_STEP: begin
                    col_reg <= status.col_last ? '0 : col_reg + COL_W'(1);
                end
                CUR_HOME: begin
                    row_reg <= '0;
                    col_reg <= '0;
                end
                CUR_SET: begin
                    row_reg <= set_row;
                    col_reg <= set_col;
                end
                default: begin
                    row_reg <= row_reg;
                end
            endcase

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ch_reg      <= s_char_code;
            irow_reg    <= s_row;
            icol_reg    <= s_col;
            icolor_reg  <= s_cell_color;
            value_reg   <= '0;
            written_reg <= 1'b0;
        end else begin
            if (cw.val_cap) begin
                value_reg <= in_range ? rdata_reg : '0;
            end
            if (cw.mem == MEM_WRITE) begin
                written_reg <= in_range;
            end
        end

        if (out_load) begin
            m_row_reg     <= row_reg;
            m_col_reg     <= col_reg;
            m_value_reg   <= value_reg;
            m_written_reg <= written_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pos_row      = m_row_reg;
    assign m_pos_col      = m_col_reg;
    assign m_cell_value   = m_value_reg;
    assign m_cell_written = m_written_reg;

endmodule

>>> tb/console_result_checker.sv
// ----------------------------------------------------------------------------
// Console result checker
// Watches the color register, the command channel and the result channel of
// the text console cursor engine. It keeps its own copy of the screen, the
// cursor and the print color, works out the result of every accepted command
// and compares each result transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module console_result_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tcce_pkg::COLOR_W-1:0]  cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [tcce_pkg::CMD_W-1:0]    s_cmd,
    input  logic [tcce_pkg::CHAR_W-1:0]   s_char_code,
    input  logic [tcce_pkg::ROW_W-1:0]    s_row,
    input  logic [tcce_pkg::COL_W-1:0]    s_col,
    input  logic [tcce_pkg::COLOR_W-1:0]  s_cell_color,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [tcce_pkg::ROW_W-1:0]    m_pos_row,
    input  logic [tcce_pkg::COL_W-1:0]    m_pos_col,
    input  logic [tcce_pkg::CELL_W-1:0]   m_cell_value,
    input  logic                          m_cell_written,
    output int                            n_errors,
    output int                            n_pending,
    output int                            n_checked,
    output int                            n_scrolls,
    output int                            n_clears
);

    import tcce_pkg::*;

    localparam int ROWS = DEF_ROWS;
    localparam int COLS = DEF_COLS;
    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CELL_W-1:0] value;
        logic              written;
    } console_result_t;

    logic [CELL_W-1:0]  screen_cells [0:ROWS*COLS-1];
    logic [ROW_W-1:0]   cursor_r;
    logic [COL_W-1:0]   cursor_c;
    logic [COLOR_W-1:0] print_attr;

    console_result_t pending_results [$];
    console_result_t want_result;

    // Moves the cursor down one row; on the last row the screen scrolls instead.
    function automatic void line_feed();
        if (int'(cursor_r) < ROWS - 1) begin
            cursor_r = cursor_r + 1'b1;
        end else begin
            for (int i = 0; i < (ROWS - 1) * COLS; i++) begin
                screen_cells[i] = screen_cells[i + COLS];
            end
            for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++) begin
                screen_cells[i] = {print_attr, CH_SPACE};
            end
            n_scrolls++;
        end
    endfunction

    function automatic void print_char(input logic [CHAR_W-1:0] ch);
        if (ch == CH_NEWLINE) begin
            cursor_c = '0;
            line_feed();
        end else if (ch == CH_RETURN) begin
            cursor_c = '0;
        end else begin
            screen_cells[int'(cursor_r) * COLS + int'(cursor_c)] = {print_attr, ch};
            if (int'(cursor_c) == COLS - 1) begin
                cursor_c = '0;
                line_feed();
            end else begin
                cursor_c = cursor_c + 1'b1;
            end
        end
    endfunction

    function automatic console_result_t predict_command(
        input logic [CMD_W-1:0]   cmd,
        input logic [CHAR_W-1:0]  ch,
        input logic [ROW_W-1:0]   row,
        input logic [COL_W-1:0]   col,
        input logic [COLOR_W-1:0] attr
    );
        console_result_t r;
        logic            in_range;
        int              idx;
        r        = '0;
        in_range = (int'(row) < ROWS) && (int'(col) < COLS);
        idx      = int'(row) * COLS + int'(col);
        case (cmd)
            CMD_PUT: begin
                print_char(ch);
            end
            CMD_CLEAR: begin
                for (int i = 0; i < ROWS * COLS; i++) begin
                    screen_cells[i] = {print_attr, CH_SPACE};
                end
                cursor_r = '0;
                cursor_c = '0;
                n_clears++;
            end
            CMD_SET: begin
                cursor_r = (int'(row) < ROWS) ? row : ROW_W'(ROWS - 1);
                cursor_c = (int'(col) < COLS) ? col : COL_W'(COLS - 1);
            end
            CMD_READ: begin
                if (in_range) begin
                    r.value = screen_cells[idx];
                end
            end
            CMD_WRITE: begin
                if (in_range) begin
                    screen_cells[idx] = {attr, ch};
                    r.written = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.row = cursor_r;
        r.col = cursor_c;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ROWS * COLS; i++) begin
                screen_cells[i] = '0;
            end
            cursor_r   = '0;
            cursor_c   = '0;
            print_attr = '0;
            pending_results.delete();
        end else begin
            if (cfg_wr_en) begin
                print_attr = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(predict_command(s_cmd, s_char_code, s_row,
                                                          s_col, s_cell_color));
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("%0t ns: result transfer with nothing outstanding, %s",
                                 $time, $sformatf("actual row %0d col %0d cell 0x%0h wr %0b",
                                 m_pos_row, m_pos_col, m_cell_value, m_cell_written));
                    end
                end else begin
                    want_result = pending_results.pop_front();
                    check_field("cursor row", int'(want_result.row), int'(m_pos_row));
                    check_field("cursor column", int'(want_result.col), int'(m_pos_col));
                    check_field("cell_value", int'(want_result.value), int'(m_cell_value));
                    check_field("cell_written", int'(want_result.written),
                                int'(m_cell_written));
                    n_checked++;
                end
            end
        end
        n_pending = pending_results.size();
    end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Text console cursor engine testbench
// Drives directed and random console commands with random gaps on both
// channels across several print colors, and lets the result checker predict
// and compare every result. Prints the verdict at the end of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    import tcce_pkg::*;

    localparam int ROWS          = DEF_ROWS;
    localparam int COLS          = DEF_COLS;
    localparam int PHASES        = 4;
    localparam int PHASE_ITEMS   = 350;
    localparam int RX_LONG_HOLD  = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 40;
    // Worst case: every command scrolls or clears and both sides stall
    // their longest, plus the clearing pass after reset.
    localparam int CYCLE_LIMIT   = 12_000_000;

    localparam logic [CMD_W-1:0] CMD_NOP_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_NOP_MID   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_NOP_LAST  = 3'd7;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [COLOR_W-1:0] cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [CMD_W-1:0]   s_cmd;
    logic [CHAR_W-1:0]  s_char_code;
    logic [ROW_W-1:0]   s_row;
    logic [COL_W-1:0]   s_col;
    logic [COLOR_W-1:0] s_cell_color;
    logic               m_valid;
    logic               m_ready;
    logic [ROW_W-1:0]   m_pos_row;
    logic [COL_W-1:0]   m_pos_col;
    logic [CELL_W-1:0]  m_cell_value;
    logic               m_cell_written;

    int n_errors;
    int n_pending;
    int n_checked;
    int n_scrolls;
    int n_clears;
    int n_sent   = 0;
    int n_colors = 0;
    int cycle_count = 0;

    bit tx_burst    = 1'b0;
    bit rx_burst    = 1'b0;
    bit rx_hold_req = 1'b0;

    always #2 aclk = ~aclk;

    text_console_cursor_engine dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_char_code    (s_char_code),
        .s_row          (s_row),
        .s_col          (s_col),
        .s_cell_color   (s_cell_color),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pos_row      (m_pos_row),
        .m_pos_col      (m_pos_col),
        .m_cell_value   (m_cell_value),
        .m_cell_written (m_cell_written)
    );

    console_result_checker u_result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_char_code    (s_char_code),
        .s_row          (s_row),
        .s_col          (s_col),
        .s_cell_color   (s_cell_color),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pos_row      (m_pos_row),
        .m_pos_col      (m_pos_col),
        .m_cell_value   (m_cell_value),
        .m_cell_written (m_cell_written),
        .n_errors       (n_errors),
        .n_pending      (n_pending),
        .n_checked      (n_checked),
        .n_scrolls      (n_scrolls),
        .n_clears       (n_clears)
    );

    // Result side: a random stall before each transfer, or one long hold-off
    // on request so that the engine backs up and stalls its command input.
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                gap = RX_LONG_HOLD;
            end else begin
                gap = rx_burst ? 0 : $urandom_range(0, 17);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, n_pending);
        $display("Some tests failed");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_cmd(
        input logic [CMD_W-1:0]   cmd,
        input logic [CHAR_W-1:0]  ch,
        input logic [ROW_W-1:0]   row,
        input logic [COL_W-1:0]   col,
        input logic [COLOR_W-1:0] attr
    );
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_char_code  <= ch;
        s_row        <= row;
        s_col        <= col;
        s_cell_color <= attr;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
        n_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (n_pending != 0);
    endtask

    task automatic set_text_color(input logic [COLOR_W-1:0] attr);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= attr;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        n_colors++;
    endtask

    // Mostly printing, with enough newlines and bottom-right cursor moves to
    // wrap and scroll often; reads and writes favor cells on the screen.
    task automatic send_random();
        int                 pick;
        logic [CMD_W-1:0]   cmd;
        logic [CHAR_W-1:0]  ch;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        pick = $urandom_range(0, 99);
        ch   = CHAR_W'($urandom_range(0, 255));
        row  = ROW_W'($urandom_range(0, 31));
        col  = COL_W'($urandom_range(0, 127));
        if (pick < 50) begin
            cmd = CMD_PUT;
            case ($urandom_range(0, 19))
                0, 1:    ch = CH_NEWLINE;
                2:       ch = CH_RETURN;
                default: begin
                end
            endcase
        end else if (pick < 52) begin
            cmd = CMD_CLEAR;
        end else if (pick < 62) begin
            cmd = CMD_SET;
            if ($urandom_range(0, 1) == 1) begin
                row = ROW_W'($urandom_range(ROWS - 5, 31));
                col = COL_W'($urandom_range(COLS - 20, 127));
            end
        end else if (pick < 94) begin
            cmd = (pick < 77) ? CMD_READ : CMD_WRITE;
            if ($urandom_range(0, 3) != 0) begin
                row = ROW_W'($urandom_range(0, ROWS - 1));
                col = COL_W'($urandom_range(0, COLS - 1));
            end
        end else begin
            cmd = CMD_W'($urandom_range(CMD_NOP_FIRST, CMD_NOP_LAST));
        end
        send_cmd(cmd, ch, row, col, COLOR_W'($urandom_range(0, 255)));
    endtask

    initial begin
        logic [COLOR_W-1:0] phase_color [PHASES];
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_cmd        = CMD_PUT;
        s_char_code  = '0;
        s_row        = '0;
        s_col        = '0;
        s_cell_color = '0;
        phase_color  = '{8'h00, 8'hFF, 8'h00, 8'h00};
        phase_color[2] = COLOR_W'($urandom_range(0, 255));
        phase_color[3] = COLOR_W'($urandom_range(0, 255));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        set_text_color(8'hA5);

        // Directed: printing, control characters, wrap with and without a
        // scroll, saturating cursor moves, out-of-range cell access, unused
        // command codes and clear.
        send_cmd(CMD_PUT, 8'h41, 5'd0, 7'd0, 8'h00);
        send_cmd(CMD_READ, 8'h00, 5'd0, 7'd0, 8'h00);
        send_cmd(CMD_PUT, 8'h00, 5'd31, 7'd127, 8'hFF);
        send_cmd(CMD_PUT, 8'hFF, 5'd0, 7'd0, 8'h00);
        send_cmd(CMD_PUT, CH_RETURN, 5'd0, 7'd0, 8'h00);
        send_cmd(CMD_PUT, CH_NEWLINE, 5'd0, 7'd0, 8'h00);
        send_cmd(CMD_SET, 8'h00, 5'd3, 7'd100, 8'h00);
        send_cmd(CMD_PUT, 8'h42, 5'd0, 7'd0, 8'h00);
        send_cmd(CMD_READ, 8'h00, 5'd3, 7'd79, 8'h00);
        send_cmd(CMD_SET, 8'hFF, 5'd31, 7'd127, 8'hFF);
        send_cmd(CMD_PUT, 8'h5A, 5'd0, 7'd0, 8'h00);
        send_cmd(CMD_READ, 8'h00, 5'd23, 7'd79, 8'h00);
        send_cmd(CMD_READ, 8'h00, 5'd24, 7'd0, 8'h00);
        send_cmd(CMD_PUT, CH_NEWLINE, 5'd0, 7'd0, 8'h00);
        send_cmd(CMD_WRITE, 8'hFF, 5'd0, 7'd0, 8'hFF);
        send_cmd(CMD_WRITE, 8'h00, 5'd24, 7'd79, 8'h00);
        send_cmd(CMD_WRITE, 8'h11, 5'd25, 7'd0, 8'h22);
        send_cmd(CMD_WRITE, 8'h33, 5'd0, 7'd80, 8'h44);
        send_cmd(CMD_WRITE, 8'h55, 5'd31, 7'd127, 8'h66);
        send_cmd(CMD_READ, 8'h00, 5'd0, 7'd0, 8'h00);
        send_cmd(CMD_READ, 8'h00, 5'd24, 7'd79, 8'h00);
        send_cmd(CMD_READ, 8'h00, 5'd31, 7'd127, 8'h00);
        send_cmd(CMD_NOP_FIRST, 8'hFF, 5'd31, 7'd127, 8'hFF);
        send_cmd(CMD_NOP_MID, 8'h00, 5'd0, 7'd0, 8'h00);
        send_cmd(CMD_CLEAR, 8'h00, 5'd0, 7'd0, 8'h00);
        send_cmd(CMD_NOP_LAST, 8'h00, 5'd12, 7'd40, 8'h00);
        send_cmd(CMD_READ, 8'h00, 5'd12, 7'd40, 8'h00);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(negedge aclk);
            set_text_color(phase_color[ph]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 50 == 0) begin
                    tx_burst = ($urandom_range(0, 3) == 0);
                    rx_burst = ($urandom_range(0, 3) == 0);
                end
                if (ph == 1 && k == 60) begin
                    // Long result stall while commands keep coming back to back.
                    rx_hold_req = 1'b1;
                    tx_burst    = 1'b1;
                end
                if (ph == 2 && k == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                send_random();
            end
        end

        wait_drained();
        repeat (END_CYCLES) @(negedge aclk);
        $display("Covered %0d commands under %0d text colors: %0d results compared,",
                 n_sent, n_colors, n_checked);
        $display("%0d scrolls and %0d screen clears.", n_scrolls, n_clears);
        if (n_errors == 0 && n_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
